[design/ate_pkg.sv]
`timescale 1ns / 1ps

package ate_pkg;

  // screen geometry and parameter store
  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int MAX_PARAMS = 8;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int PARAM_W = 14;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 3;

  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]   ROWS_V    = ROW_W'(ROWS);
  localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(COLS - 1);
  localparam logic [COL_W-1:0]   COLS_V    = COL_W'(COLS);
  localparam logic [CNT_W-1:0]   PARAMS_V  = CNT_W'(MAX_PARAMS);
  localparam logic [PARAM_W-1:0] ACC_MAX   = PARAM_W'(9999);

  // result kinds
  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_SCROLL = 3'd2;
  localparam logic [2:0] KIND_ATTR   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;
  localparam logic [2:0] KIND_BELL   = 3'd5;

  // control and sequence bytes
  localparam logic [7:0] CH_BEL    = 8'd7;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] FIN_UP    = 8'h41;
  localparam logic [7:0] FIN_DOWN  = 8'h42;
  localparam logic [7:0] FIN_RIGHT = 8'h43;
  localparam logic [7:0] FIN_LEFT  = 8'h44;
  localparam logic [7:0] FIN_POS   = 8'h48;
  localparam logic [7:0] FIN_POS_F = 8'h66;
  localparam logic [7:0] FIN_ED    = 8'h4a;
  localparam logic [7:0] FIN_EL    = 8'h4b;
  localparam logic [7:0] FIN_DSR   = 8'h6e;
  localparam logic [7:0] FIN_SAVE  = 8'h73;
  localparam logic [7:0] FIN_REST  = 8'h75;
  localparam logic [7:0] FIN_SGR   = 8'h6d;

  // parameter values with a meaning
  localparam logic [PARAM_W-1:0] P_ZERO     = PARAM_W'(0);
  localparam logic [PARAM_W-1:0] P_ONE      = PARAM_W'(1);
  localparam logic [PARAM_W-1:0] P_TWO      = PARAM_W'(2);
  localparam logic [PARAM_W-1:0] P_UNDER    = PARAM_W'(4);
  localparam logic [PARAM_W-1:0] P_BLINK    = PARAM_W'(5);
  localparam logic [PARAM_W-1:0] P_REPORT   = PARAM_W'(6);
  localparam logic [PARAM_W-1:0] P_INVERSE  = PARAM_W'(7);
  localparam logic [PARAM_W-1:0] P_HIDDEN   = PARAM_W'(8);
  localparam logic [PARAM_W-1:0] P_FG_FIRST = PARAM_W'(30);
  localparam logic [PARAM_W-1:0] P_FG_LAST  = PARAM_W'(37);
  localparam logic [PARAM_W-1:0] P_BG_FIRST = PARAM_W'(40);
  localparam logic [PARAM_W-1:0] P_BG_LAST  = PARAM_W'(47);

  // colours
  localparam logic [2:0] COL_BLACK  = 3'd0;
  localparam logic [2:0] COL_RED    = 3'd1;
  localparam logic [2:0] COL_YELLOW = 3'd3;
  localparam logic [2:0] COL_WHITE  = 3'd7;

  typedef struct packed {
    logic [2:0] fg;
    logic [2:0] bg;
    logic       ul;
    logic       inv;
  } attr_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] row_a;
    logic [COL_W-1:0] col_a;
    logic [ROW_W-1:0] row_b;
    logic [COL_W-1:0] col_b;
    logic [ROW_W-1:0] line_count;
    logic [2:0]       fg_color;
    logic [2:0]       bg_color;
    logic             underline;
  } result_t;

endpackage

[design/ate_attr_unit.sv]
`timescale 1ns / 1ps

module ate_attr_unit (
  input  ate_pkg::attr_t                   attr_in,
  input  logic [ate_pkg::PARAM_W-1:0]      param,
  output ate_pkg::attr_t                   attr_out
);

  logic [ate_pkg::PARAM_W-1:0] fg_off;
  logic [ate_pkg::PARAM_W-1:0] bg_off;

  assign fg_off = param - ate_pkg::P_FG_FIRST;
  assign bg_off = param - ate_pkg::P_BG_FIRST;

  // one graphic rendition parameter applied to the attribute set
  always_comb begin
    attr_out = attr_in;
    if (param == ate_pkg::P_ZERO) begin
      attr_out.fg  = ate_pkg::COL_WHITE;
      attr_out.bg  = ate_pkg::COL_BLACK;
      attr_out.ul  = 1'b0;
      attr_out.inv = 1'b0;
    end else if (param == ate_pkg::P_ONE) begin
      attr_out.fg = ate_pkg::COL_YELLOW;
    end else if (param == ate_pkg::P_UNDER) begin
      attr_out.ul = 1'b1;
    end else if (param == ate_pkg::P_BLINK) begin
      attr_out.fg = ate_pkg::COL_RED;
    end else if (param == ate_pkg::P_INVERSE) begin
      attr_out.inv = 1'b1;
    end else if (param == ate_pkg::P_HIDDEN) begin
      attr_out.fg = ate_pkg::COL_BLACK;
      attr_out.bg = ate_pkg::COL_BLACK;
    end else if (param >= ate_pkg::P_FG_FIRST && param <= ate_pkg::P_FG_LAST) begin
      attr_out.fg = fg_off[2:0];
    end else if (param >= ate_pkg::P_BG_FIRST && param <= ate_pkg::P_BG_LAST) begin
      attr_out.bg = bg_off[2:0];
    end
  end

endmodule

[design/ansi_terminal_escape_parser.sv]
`timescale 1ns / 1ps

// Terminal escape-sequence parser: one received byte in, up to two screen
// commands out.
// Input channel s_axis: tdata carries the byte, tuser the raw flag (control
// bytes are then written as glyphs). Output channel m_axis: tuser carries the
// command kind, tlast marks the final command of a byte, tdata the fields.
// Configuration channel cfg: one bit, line wrap on or off, taken at any time.
// Timing: a byte is taken in the idle state and decoded in the next cycle. A
// graphic rendition final byte then walks the stored parameters through the
// attribute unit, one per cycle. Each command is then held on m_axis until
// taken, one per cycle.
// s_axis_tready is high only while the block is idle; a stalled receiver
// holds the command and the block waits with it.
// Reset (rst, synchronous): cursor and saved cursor at home, white on black,
// no underline or inverse, parser idle, parameters cleared, line wrap on.
module ansi_terminal_escape_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tuser,   // raw_mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // char_code, row_a, col_a, row_b, col_b, line_count, fg_color, bg_color,
  // underline, zero pad
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data        // line_wrap
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_ATTR = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  localparam int RW = ate_pkg::ROW_W;
  localparam int CW = ate_pkg::COL_W;
  localparam int PW = ate_pkg::PARAM_W;

  logic [1:0] state;
  logic       line_wrap;
  logic [7:0] in_byte;
  logic       in_raw;

  logic [RW-1:0] cursor_row, saved_row;
  logic [CW-1:0] cursor_col, saved_col;
  logic          escape_seen, in_sequence;
  logic [PW-1:0] digit_accum;
  logic [ate_pkg::CNT_W-1:0] param_count;
  logic [PW-1:0] params [ate_pkg::MAX_PARAMS];
  ate_pkg::attr_t attr;

  ate_pkg::result_t res [2];
  logic [1:0] nres;
  logic       out_idx;
  logic [ate_pkg::CNT_W-1:0] walk_idx, walk_cnt;

  // decode results
  logic [RW-1:0] row_next, srow_next, pc_row;
  logic [CW-1:0] col_next, scol_next, pc_col, tab_col;
  logic          esc_next, seq_next, do_put, walk_go;
  logic [PW-1:0] acc_next, p0, p1, amt;
  logic [ate_pkg::CNT_W-1:0] cnt_next;
  logic [PW-1:0] params_next [ate_pkg::MAX_PARAMS];
  ate_pkg::result_t res_next [2];
  logic [1:0]    nres_next;
  logic [16:0]   acc_calc;
  logic [PW:0]   row_sum, col_sum;
  logic [PW-1:0] p0_dec, p1_dec;

  // attribute walk
  ate_pkg::attr_t attr_nx;
  ate_pkg::result_t attr_res;

  function automatic ate_pkg::result_t mk_res(
    input logic [2:0]    kind,
    input logic [7:0]    ch,
    input logic [RW-1:0] ra,
    input logic [CW-1:0] ca,
    input logic [RW-1:0] rb,
    input logic [CW-1:0] cb,
    input logic [RW-1:0] lc
  );
    ate_pkg::result_t r;
    r            = '0;
    r.kind       = kind;
    r.char_code  = ch;
    r.row_a      = ra;
    r.col_a      = ca;
    r.row_b      = rb;
    r.col_b      = cb;
    r.line_count = lc;
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] c);
    return (c > ate_pkg::LAST_COL) ? ate_pkg::LAST_COL : c;
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  assign acc_calc = 17'(digit_accum) * 17'd10 + 17'(in_byte - ate_pkg::CH_ZERO);
  assign tab_col  = {cursor_col[CW-1:3], 3'b000} + CW'(8);

  // byte decode: next parser and cursor state, and up to two commands
  always_comb begin
    row_next    = cursor_row;
    col_next    = cursor_col;
    srow_next   = saved_row;
    scol_next   = saved_col;
    esc_next    = escape_seen;
    seq_next    = in_sequence;
    acc_next    = digit_accum;
    cnt_next    = param_count;
    params_next = params;
    res_next[0] = '0;
    res_next[1] = '0;
    nres_next   = 2'd0;
    walk_go     = 1'b0;
    do_put      = 1'b0;
    pc_row      = cursor_row;
    pc_col      = cursor_col;
    p0          = '0;
    p1          = '0;
    amt         = '0;
    row_sum     = '0;
    col_sum     = '0;
    p0_dec      = '0;
    p1_dec      = '0;

    if (in_byte < ate_pkg::CH_SPACE) begin
      if (in_raw) begin
        do_put = 1'b1;
      end else begin
        unique case (in_byte)
          ate_pkg::CH_BEL: begin
            res_next[nres_next[0]] = mk_res(ate_pkg::KIND_BELL, '0, '0, '0, '0, '0, '0);
            nres_next = nres_next + 2'd1;
          end
          ate_pkg::CH_BS: begin
            if (cursor_col != '0) col_next = cursor_col - CW'(1);
          end
          ate_pkg::CH_TAB: begin
            col_next = clamp_col(tab_col);
          end
          ate_pkg::CH_LF: begin
            if (cursor_row < ate_pkg::LAST_ROW) begin
              row_next = cursor_row + RW'(1);
            end else begin
              res_next[nres_next[0]] = mk_res(ate_pkg::KIND_SCROLL, '0, '0, '0, '0, '0,
                                              RW'(1));
              nres_next = nres_next + 2'd1;
            end
          end
          ate_pkg::CH_FF: begin
            res_next[0] = mk_res(ate_pkg::KIND_SCROLL, '0, '0, '0, '0, '0,
                                 ate_pkg::ROWS_V);
            res_next[1] = mk_res(ate_pkg::KIND_FILL, '0, '0, '0, ate_pkg::LAST_ROW,
                                 ate_pkg::LAST_COL, '0);
            nres_next = 2'd2;
            row_next  = '0;
            col_next  = '0;
          end
          ate_pkg::CH_CR: begin
            col_next = '0;
          end
          ate_pkg::CH_ESC: begin
            esc_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (escape_seen) begin
      // introducer: open a control sequence with cleared parameters
      if (in_byte == ate_pkg::CH_LBRACK) begin
        seq_next = 1'b1;
        cnt_next = '0;
        acc_next = '0;
        for (int i = 0; i < ate_pkg::MAX_PARAMS; i++) params_next[i] = '0;
      end
      esc_next = 1'b0;
    end else if (in_sequence) begin
      if (in_byte >= ate_pkg::CH_ZERO && in_byte <= ate_pkg::CH_NINE) begin
        acc_next = (acc_calc > 17'(ate_pkg::ACC_MAX)) ? ate_pkg::ACC_MAX : acc_calc[PW-1:0];
      end else begin
        // store the pending parameter, dropped when the store is full
        if (param_count < ate_pkg::PARAMS_V) begin
          params_next[param_count[ate_pkg::IDX_W-1:0]] = digit_accum;
          cnt_next = param_count + ate_pkg::CNT_W'(1);
        end
        acc_next = '0;
        if (in_byte != ate_pkg::CH_SEMI) begin
          seq_next = 1'b0;
          p0       = params_next[0];
          p1       = params_next[1];
          amt      = (p0 == '0) ? ate_pkg::P_ONE : p0;
          p0_dec   = p0 - PW'(1);
          p1_dec   = p1 - PW'(1);
          row_sum  = (PW+1)'(cursor_row) + (PW+1)'(amt);
          col_sum  = (PW+1)'(cursor_col) + (PW+1)'(amt);
          unique case (in_byte)
            ate_pkg::FIN_POS, ate_pkg::FIN_POS_F: begin
              if (p0 == '0) row_next = '0;
              else if (p0 > PW'(ate_pkg::ROWS_V)) row_next = ate_pkg::LAST_ROW;
              else row_next = p0_dec[RW-1:0];
              if (p1 == '0) col_next = '0;
              else if (p1 > PW'(ate_pkg::COLS_V)) col_next = ate_pkg::LAST_COL;
              else col_next = p1_dec[CW-1:0];
            end
            ate_pkg::FIN_UP: begin
              if (PW'(cursor_row) > amt) row_next = cursor_row - amt[RW-1:0];
              else row_next = '0;
            end
            ate_pkg::FIN_DOWN: begin
              if (row_sum > (PW+1)'(ate_pkg::LAST_ROW)) row_next = ate_pkg::LAST_ROW;
              else row_next = row_sum[RW-1:0];
            end
            ate_pkg::FIN_RIGHT: begin
              if (col_sum > (PW+1)'(ate_pkg::LAST_COL)) col_next = ate_pkg::LAST_COL;
              else col_next = col_sum[CW-1:0];
            end
            ate_pkg::FIN_LEFT: begin
              if (PW'(cursor_col) > amt) col_next = cursor_col - amt[CW-1:0];
              else col_next = '0;
            end
            ate_pkg::FIN_ED: begin
              if (p0 == ate_pkg::P_ZERO) begin
                if (cursor_row < ate_pkg::LAST_ROW) begin
                  res_next[nres_next[0]] = mk_res(ate_pkg::KIND_FILL, '0,
                    cursor_row + RW'(1), '0, ate_pkg::LAST_ROW, ate_pkg::LAST_COL, '0);
                  nres_next = nres_next + 2'd1;
                end
                res_next[nres_next[0]] = mk_res(ate_pkg::KIND_FILL, '0, cursor_row,
                  cursor_col, cursor_row, ate_pkg::LAST_COL, '0);
                nres_next = nres_next + 2'd1;
              end else if (p0 == ate_pkg::P_ONE) begin
                if (cursor_row != '0) begin
                  res_next[nres_next[0]] = mk_res(ate_pkg::KIND_FILL, '0, '0, '0,
                    cursor_row - RW'(1), ate_pkg::LAST_COL, '0);
                  nres_next = nres_next + 2'd1;
                end
                res_next[nres_next[0]] = mk_res(ate_pkg::KIND_FILL, '0, cursor_row, '0,
                  cursor_row, clamp_col(cursor_col), '0);
                nres_next = nres_next + 2'd1;
              end else if (p0 == ate_pkg::P_TWO) begin
                res_next[0] = mk_res(ate_pkg::KIND_SCROLL, '0, '0, '0, '0, '0,
                                     ate_pkg::ROWS_V);
                res_next[1] = mk_res(ate_pkg::KIND_FILL, '0, '0, '0, ate_pkg::LAST_ROW,
                                     ate_pkg::LAST_COL, '0);
                nres_next = 2'd2;
                row_next  = '0;
                col_next  = '0;
              end
            end
            ate_pkg::FIN_EL: begin
              if (p0 == ate_pkg::P_ZERO) begin
                res_next[0] = mk_res(ate_pkg::KIND_FILL, '0, cursor_row, cursor_col,
                                     cursor_row, ate_pkg::LAST_COL, '0);
                nres_next = 2'd1;
              end else if (p0 == ate_pkg::P_ONE) begin
                res_next[0] = mk_res(ate_pkg::KIND_FILL, '0, cursor_row, '0,
                                     cursor_row, clamp_col(cursor_col), '0);
                nres_next = 2'd1;
              end else if (p0 == ate_pkg::P_TWO) begin
                res_next[0] = mk_res(ate_pkg::KIND_FILL, '0, cursor_row, '0,
                                     cursor_row, ate_pkg::LAST_COL, '0);
                nres_next = 2'd1;
              end
            end
            ate_pkg::FIN_DSR: begin
              if (p0 == ate_pkg::P_REPORT) begin
                res_next[0] = mk_res(ate_pkg::KIND_REPORT, '0, cursor_row + RW'(1),
                                     clamp_col(cursor_col) + CW'(1), '0, '0, '0);
                nres_next = 2'd1;
              end
            end
            ate_pkg::FIN_SAVE: begin
              srow_next = cursor_row;
              scol_next = cursor_col;
            end
            ate_pkg::FIN_REST: begin
              row_next = saved_row;
              col_next = saved_col;
            end
            ate_pkg::FIN_SGR: begin
              walk_go = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end else begin
      do_put = 1'b1;
    end

    // printable write with wrap or stick at the last column
    if (do_put) begin
      if (cursor_col >= ate_pkg::COLS_V) begin
        if (line_wrap) begin
          pc_col = '0;
          if (cursor_row < ate_pkg::LAST_ROW) begin
            pc_row = cursor_row + RW'(1);
          end else begin
            res_next[0] = mk_res(ate_pkg::KIND_SCROLL, '0, '0, '0, '0, '0, RW'(1));
            nres_next   = 2'd1;
          end
        end else begin
          pc_col = ate_pkg::LAST_COL;
        end
      end
      res_next[nres_next[0]] = mk_res(ate_pkg::KIND_CHAR, in_byte, pc_row, pc_col,
                                      '0, '0, '0);
      nres_next = nres_next + 2'd1;
      row_next  = pc_row;
      col_next  = pc_col + CW'(1);
      if (!line_wrap && col_next >= ate_pkg::COLS_V) col_next = ate_pkg::LAST_COL;
    end
  end

  // shared attribute unit, one stored parameter per cycle
  ate_attr_unit u_attr (
    .attr_in  (attr),
    .param    (params[walk_idx[ate_pkg::IDX_W-1:0]]),
    .attr_out (attr_nx)
  );

  always_comb begin
    attr_res           = '0;
    attr_res.kind      = ate_pkg::KIND_ATTR;
    attr_res.fg_color  = attr_nx.inv ? attr_nx.bg : attr_nx.fg;
    attr_res.bg_color  = attr_nx.inv ? attr_nx.fg : attr_nx.bg;
    attr_res.underline = attr_nx.ul;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_wrap   <= 1'b1;
      cursor_row  <= '0;
      cursor_col  <= '0;
      saved_row   <= '0;
      saved_col   <= '0;
      escape_seen <= 1'b0;
      in_sequence <= 1'b0;
      digit_accum <= '0;
      param_count <= '0;
      for (int i = 0; i < ate_pkg::MAX_PARAMS; i++) params[i] <= '0;
      attr.fg     <= ate_pkg::COL_WHITE;
      attr.bg     <= ate_pkg::COL_BLACK;
      attr.ul     <= 1'b0;
      attr.inv    <= 1'b0;
      nres        <= 2'd0;
      out_idx     <= 1'b0;
      walk_idx    <= '0;
      walk_cnt    <= '0;
    end else begin
      if (cfg_valid) line_wrap <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_byte <= s_axis_tdata;
            in_raw  <= s_axis_tuser;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cursor_row  <= row_next;
          cursor_col  <= col_next;
          saved_row   <= srow_next;
          saved_col   <= scol_next;
          escape_seen <= esc_next;
          in_sequence <= seq_next;
          digit_accum <= acc_next;
          param_count <= cnt_next;
          params      <= params_next;
          res[0]      <= res_next[0];
          res[1]      <= res_next[1];
          nres        <= nres_next;
          out_idx     <= 1'b0;
          walk_idx    <= '0;
          walk_cnt    <= cnt_next;
          if (walk_go) state <= ST_ATTR;
          else if (nres_next != 2'd0) state <= ST_SEND;
          else state <= ST_IDLE;
        end
        ST_ATTR: begin
          attr     <= attr_nx;
          walk_idx <= walk_idx + ate_pkg::CNT_W'(1);
          if (walk_idx + ate_pkg::CNT_W'(1) >= walk_cnt) begin
            res[0] <= attr_res;
            nres   <= 2'd1;
            state  <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (m_axis_tready) begin
            if (m_axis_tlast) state <= ST_IDLE;
            else out_idx <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output channel
  assign m_axis_tvalid = (state == ST_SEND);
  assign m_axis_tlast  = ({1'b0, out_idx} == nres - 2'd1);
  assign m_axis_tuser  = res[out_idx].kind;
  assign m_axis_tdata  = {4'b0000,
                          res[out_idx].underline,
                          res[out_idx].bg_color,
                          res[out_idx].fg_color,
                          res[out_idx].line_count,
                          res[out_idx].col_b,
                          res[out_idx].row_b,
                          res[out_idx].col_a,
                          res[out_idx].row_a,
                          res[out_idx].char_code};

endmodule
